// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wsc_pkg.sv =====
`default_nettype none
package wsc_pkg;

    localparam int MIN_WHEEL_ANGLE  = 500;
    localparam int TURN_SPEED_FLOOR = 100;
    localparam int SEAM_TOLERANCE   = 1000;
    localparam int FORWARD_DIVISOR  = 4;
    localparam int FULL_TURN        = 36000;
    localparam int CORDIC_STEPS     = 16;
    localparam int SQRT_STEPS       = 17;
    localparam int DIV_STEPS        = 16;

    localparam logic signed [26:0] ACC_HALF = 27'sd18432000;
    localparam logic signed [26:0] ACC_FULL = 27'sd36864000;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_TURN    = 2'd1,
        MODE_ARRIVED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_WAYPOINT_X   = 3'd0,
        REG_WAYPOINT_Y   = 3'd1,
        REG_ARRIVE_TOL   = 3'd2,
        REG_YAW_TOL      = 3'd3,
        REG_MAX_WHEEL    = 3'd4,
        REG_MAX_TURN     = 3'd5,
        REG_MAX_MOVE     = 3'd6,
        REG_FULL_DIST    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic [31:0]        arr_sq;
        logic [31:0]        fsd_sq;
        logic [14:0]        yaw_tol;
        logic [13:0]        max_wheel;
        logic [15:0]        max_turn;
        logic [15:0]        max_move;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [15:0]        yaw;
        logic [31:0]        dxx;
        logic [31:0]        dyy;
        logic               arrive;
        logic               far;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [26:0] cz;
        logic [33:0]        sq_val;
        logic [17:0]        sq_rem;
        logic [16:0]        sq_root;
        logic [15:0]        bearing;
        mode_t              mode;
        logic signed [14:0] wheel;
        logic [15:0]        fwd_speed;
        logic               span_pos;
        logic [15:0]        span_mag;
        logic [15:0]        lo;
        logic [15:0]        hi;
        logic [15:0]        dvd;
        logic [15:0]        drem;
        logic [15:0]        quo;
    } item_t;

    // arctan(2^-i) in units of 1/1024 of 0.01 degree
    function automatic logic [22:0] arc_of(input logic [4:0] idx);
        logic [22:0] a;
        case (idx)
            5'd0:    a = 23'd4608000;
            5'd1:    a = 23'd2720261;
            5'd2:    a = 23'd1437311;
            5'd3:    a = 23'd729602;
            5'd4:    a = 23'd366217;
            5'd5:    a = 23'd183287;
            5'd6:    a = 23'd91666;
            5'd7:    a = 23'd45836;
            5'd8:    a = 23'd22918;
            5'd9:    a = 23'd11459;
            5'd10:   a = 23'd5730;
            5'd11:   a = 23'd2865;
            5'd12:   a = 23'd1432;
            5'd13:   a = 23'd716;
            5'd14:   a = 23'd358;
            5'd15:   a = 23'd179;
            default: a = 23'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wsc_front.sv =====
`default_nettype none
module wsc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wsc_pkg::cfg_t           cfg,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire logic signed [15:0] robot_x,
    input  wire logic signed [15:0] robot_y,
    input  wire logic [15:0]        robot_yaw,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output wsc_pkg::item_t          dn_item
);
    import wsc_pkg::*;

    logic  a_valid_reg, b_valid_reg, c_valid_reg;
    logic  a_adv, b_adv, c_adv;
    item_t a_reg, b_reg, c_reg;
    item_t a_next, b_next, c_next;
    logic [32:0] d2;

    assign c_adv    = !c_valid_reg || dn_ready;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign up_ready = a_adv;
    assign dn_valid = c_valid_reg;
    assign dn_item  = c_reg;

    always_comb
    begin
        a_next     = '0;
        a_next.dx  = {cfg.wx[15], cfg.wx} - {robot_x[15], robot_x};
        a_next.dy  = {cfg.wy[15], cfg.wy} - {robot_y[15], robot_y};
        a_next.yaw = (robot_yaw >= 16'(FULL_TURN)) ? robot_yaw - 16'(FULL_TURN) : robot_yaw;

        b_next     = a_reg;
        b_next.dxx = 32'(a_reg.dx * a_reg.dx);
        b_next.dyy = 32'(a_reg.dy * a_reg.dy);

        d2              = {1'b0, b_reg.dxx} + {1'b0, b_reg.dyy};
        c_next          = b_reg;
        c_next.arrive   = (d2 <= {1'b0, cfg.arr_sq});
        c_next.far      = (d2 > {1'b0, cfg.fsd_sq});
        c_next.cx       = {{3{b_reg.dx[16]}}, b_reg.dx, 14'd0};
        c_next.cy       = {{3{b_reg.dy[16]}}, b_reg.dy, 14'd0};
        c_next.cz       = '0;
        // start from the opposite half-plane when the target lies behind
        if (b_reg.dx[16])
        begin
            c_next.cx = -c_next.cx;
            c_next.cy = -c_next.cy;
            c_next.cz = ACC_HALF;
        end
        c_next.sq_val  = {1'b0, d2};
        c_next.sq_rem  = '0;
        c_next.sq_root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv) a_valid_reg <= up_valid;
            if (b_adv) b_valid_reg <= a_valid_reg;
            if (c_adv) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && up_valid) a_reg <= a_next;
        if (b_adv && a_valid_reg) b_reg <= b_next;
        if (c_adv && b_valid_reg) c_reg <= c_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wsc_cord_cell.sv =====
`default_nettype none
module wsc_cord_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [4:0] idx,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wsc_pkg::item_t  up_item,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output wsc_pkg::item_t  dn_item
);
    import wsc_pkg::*;

    logic  valid_reg, adv;
    item_t item_reg, item_next;
    logic signed [33:0] xs, ys;
    logic [19:0] r;
    logic [18:0] trial;

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        item_next = up_item;
        xs = up_item.cx >>> idx;
        ys = up_item.cy >>> idx;
        // one rotation step towards the x axis
        if (idx < 5'(CORDIC_STEPS))
        begin
            if (!up_item.cy[33])
            begin
                item_next.cx = up_item.cx + ys;
                item_next.cy = up_item.cy - xs;
                item_next.cz = up_item.cz + $signed({4'd0, arc_of(idx)});
            end
            else
            begin
                item_next.cx = up_item.cx - ys;
                item_next.cy = up_item.cy + xs;
                item_next.cz = up_item.cz - $signed({4'd0, arc_of(idx)});
            end
        end
        // one root bit from the next two radicand bits
        r     = {up_item.sq_rem, up_item.sq_val[33:32]};
        trial = {up_item.sq_root, 2'b01};
        item_next.sq_val = {up_item.sq_val[31:0], 2'b00};
        if (r >= {1'b0, trial})
        begin
            item_next.sq_rem  = 18'(r - {1'b0, trial});
            item_next.sq_root = {up_item.sq_root[15:0], 1'b1};
        end
        else
        begin
            item_next.sq_rem  = r[17:0];
            item_next.sq_root = {up_item.sq_root[15:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid) item_reg <= item_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wsc_mid.sv =====
`default_nettype none
module wsc_mid (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wsc_pkg::cfg_t  cfg,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wsc_pkg::item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output wsc_pkg::item_t dn_item
);
    import wsc_pkg::*;

    logic  a_valid_reg, b_valid_reg, c_valid_reg;
    logic  a_adv, b_adv, c_adv;
    item_t a_reg, b_reg, c_reg;
    item_t a_next, b_next, c_next;

    logic signed [26:0] zf;
    logic [16:0] t1;
    logic signed [17:0] t, y, yt, diff, err, span;
    logic seam, hold, turn, neg;
    logic [15:0] ang;
    logic [16:0] root_div;
    logic [31:0] prod;

    assign c_adv    = !c_valid_reg || dn_ready;
    assign b_adv    = !b_valid_reg || c_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign up_ready = a_adv;
    assign dn_valid = c_valid_reg;
    assign dn_item  = c_reg;

    always_comb
    begin
        // bearing: wrap, round, fold a full turn back to zero
        a_next = up_item;
        zf     = up_item.cz[26] ? up_item.cz + ACC_FULL : up_item.cz;
        t1     = 17'((zf + 27'sd512) >>> 10);
        a_next.bearing = (t1 >= 17'(FULL_TURN)) ? 16'(t1 - 17'(FULL_TURN)) : t1[15:0];

        // heading error, seam handling, steering and speed operands
        b_next = a_reg;
        t      = $signed({2'b00, a_reg.bearing});
        y      = $signed({2'b00, a_reg.yaw});
        yt     = $signed({3'b000, cfg.yaw_tol});
        diff   = (t > y) ? t - y : y - t;
        seam   = (t > 18'(FULL_TURN - SEAM_TOLERANCE) && y < 18'(SEAM_TOLERANCE)) ||
                 (y > 18'(FULL_TURN - SEAM_TOLERANCE) && t < 18'(SEAM_TOLERANCE));
        err    = seam ? 18'(FULL_TURN) - diff : diff;
        hold   = (t > 18'(FULL_TURN) - yt && y < yt) || (y > 18'(FULL_TURN) - yt && t < yt);
        turn   = !hold && (err > yt);
        if (err > $signed({4'd0, cfg.max_wheel}))
            ang = {2'b00, cfg.max_wheel};
        else if (err < 18'(MIN_WHEEL_ANGLE))
            ang = 16'(MIN_WHEEL_ANGLE);
        else
            ang = err[15:0];
        if (y > t)
            neg = (18'(FULL_TURN) - diff < diff);
        else
            neg = !(18'(FULL_TURN) - diff < diff);
        b_next.wheel = neg ? 15'(-ang) : 15'(ang);
        b_next.lo    = (err < t) ? err[15:0] : t[15:0];
        b_next.hi    = (err < t) ? t[15:0] : err[15:0];
        span         = $signed({2'b00, cfg.max_turn}) - 18'(TURN_SPEED_FLOOR);
        b_next.span_pos = !span[17];
        b_next.span_mag = span[17] ? 16'(-span) : span[15:0];
        root_div        = a_reg.sq_root / 17'(FORWARD_DIVISOR);
        b_next.fwd_speed = a_reg.far ? cfg.max_move : root_div[15:0];
        if (a_reg.arrive)
            b_next.mode = MODE_ARRIVED;
        else if (turn)
            b_next.mode = MODE_TURN;
        else
            b_next.mode = MODE_FORWARD;

        // dividend for the turn speed ratio
        c_next      = b_reg;
        prod        = b_reg.span_mag * b_reg.lo;
        c_next.dvd  = prod[15:0];
        c_next.drem = prod[31:16];
        c_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv) a_valid_reg <= up_valid;
            if (b_adv) b_valid_reg <= a_valid_reg;
            if (c_adv) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && up_valid) a_reg <= a_next;
        if (b_adv && a_valid_reg) b_reg <= b_next;
        if (c_adv && b_valid_reg) c_reg <= c_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wsc_div_cell.sv =====
`default_nettype none
module wsc_div_cell (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wsc_pkg::item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output wsc_pkg::item_t dn_item
);
    import wsc_pkg::*;

    logic  valid_reg, adv;
    item_t item_reg, item_next;
    logic [16:0] r;
    logic ge;

    assign adv      = !valid_reg || dn_ready;
    assign up_ready = adv;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    // one restoring division step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        item_next      = up_item;
        r              = {up_item.drem, up_item.dvd[15]};
        ge             = (r >= {1'b0, up_item.hi});
        item_next.drem = ge ? 16'(r - {1'b0, up_item.hi}) : r[15:0];
        item_next.dvd  = {up_item.dvd[14:0], 1'b0};
        item_next.quo  = {up_item.quo[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid) item_reg <= item_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wsc_out.sv =====
`default_nettype none
module wsc_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wsc_pkg::item_t     up_item,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output logic [1:0]         drive_mode,
    output logic [15:0]        speed,
    output logic signed [14:0] wheel_angle
);
    import wsc_pkg::*;

    logic valid_reg, adv;
    logic [1:0]  mode_reg;
    logic [15:0] speed_reg, speed_next, q, turn_speed;
    logic signed [14:0] wheel_reg, wheel_next;

    assign adv         = !valid_reg || dn_ready;
    assign up_ready    = adv;
    assign dn_valid    = valid_reg;
    assign drive_mode  = mode_reg;
    assign speed       = speed_reg;
    assign wheel_angle = wheel_reg;

    always_comb
    begin
        // a zero denominator gives a zero ratio
        q          = (up_item.hi == 16'd0) ? 16'd0 : up_item.quo;
        turn_speed = up_item.span_pos ? 16'(q + 16'(TURN_SPEED_FLOOR))
                                      : 16'(16'(TURN_SPEED_FLOOR) - q);
        case (up_item.mode)
            MODE_ARRIVED:
            begin
                speed_next = '0;
                wheel_next = '0;
            end
            MODE_TURN:
            begin
                speed_next = turn_speed;
                wheel_next = up_item.wheel;
            end
            default:
            begin
                speed_next = up_item.fwd_speed;
                wheel_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            mode_reg  <= up_item.mode;
            speed_reg <= speed_next;
            wheel_reg <= wheel_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/waypoint_steering_controller_unit.sv =====
// Waypoint steering controller.
// Input channel in_valid/in_ready carries one pose word (robot_x, robot_y,
// robot_yaw); output channel out_valid/out_ready carries one drive word
// (drive_mode, speed, wheel_angle) per pose, in order.
// Configuration: write cfg_data to register cfg_index when cfg_we is high;
// write only while no pose is in flight.
// Pipeline from acceptance to out_valid: 3 front stages, 17 CORDIC and
// square-root cells, 3 decision stages, 16 divider cells, output register.
// Throughput: one pose per cycle unless out_ready stalls; each cell is a register.
// Each cell advances when it is empty or its neighbour downstream advances,
// so bubbles close up and in_ready stays high while out_ready is low until
// the whole chain is full.
// Reset clears all valid bits and loads the register defaults (waypoint at
// the origin, tolerance 10 cm / 5 deg, clamp 45 deg, speeds 500 and 1000,
// full speed beyond 100 cm).
`default_nettype none
`include "assert_macros.svh"
module waypoint_steering_controller_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] robot_x,
    input  wire logic signed [15:0] robot_y,
    input  wire logic [15:0]        robot_yaw,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              drive_mode,
    output logic [15:0]             speed,
    output logic signed [14:0]      wheel_angle
);
    import wsc_pkg::*;

    localparam int NCELL = SQRT_STEPS;

    logic signed [15:0] wx_reg, wy_reg;
    logic [15:0] arr_tol_reg, max_turn_reg, max_move_reg, fsd_reg;
    logic [14:0] yaw_tol_reg;
    logic [13:0] max_wheel_reg;
    logic [31:0] arr_sq_reg, fsd_sq_reg;
    cfg_t cfg;

    logic  cc_valid [0:NCELL];
    logic  cc_ready [0:NCELL];
    item_t cc_item  [0:NCELL];
    logic  dv_valid [0:DIV_STEPS];
    logic  dv_ready [0:DIV_STEPS];
    item_t dv_item  [0:DIV_STEPS];

    // configuration registers; squares are held ready for the distance compares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg        <= '0;
            wy_reg        <= '0;
            arr_tol_reg   <= 16'd10;
            yaw_tol_reg   <= 15'd500;
            max_wheel_reg <= 14'd4500;
            max_turn_reg  <= 16'd500;
            max_move_reg  <= 16'd1000;
            fsd_reg       <= 16'd100;
            arr_sq_reg    <= 32'd100;
            fsd_sq_reg    <= 32'd10000;
        end
        else
        begin
            arr_sq_reg <= arr_tol_reg * arr_tol_reg;
            fsd_sq_reg <= fsd_reg * fsd_reg;
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_WAYPOINT_X: wx_reg        <= cfg_data;
                    REG_WAYPOINT_Y: wy_reg        <= cfg_data;
                    REG_ARRIVE_TOL: arr_tol_reg   <= cfg_data;
                    REG_YAW_TOL:    yaw_tol_reg   <= cfg_data[14:0];
                    REG_MAX_WHEEL:  max_wheel_reg <= cfg_data[13:0];
                    REG_MAX_TURN:   max_turn_reg  <= cfg_data;
                    REG_MAX_MOVE:   max_move_reg  <= cfg_data;
                    REG_FULL_DIST:  fsd_reg       <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.wx        = wx_reg;
        cfg.wy        = wy_reg;
        cfg.arr_sq    = arr_sq_reg;
        cfg.fsd_sq    = fsd_sq_reg;
        cfg.yaw_tol   = yaw_tol_reg;
        cfg.max_wheel = max_wheel_reg;
        cfg.max_turn  = max_turn_reg;
        cfg.max_move  = max_move_reg;
    end

    // offsets, yaw fold, squared distance, arrival and far tests, CORDIC start vector
    wsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (in_valid),
        .up_ready  (in_ready),
        .robot_x   (robot_x),
        .robot_y   (robot_y),
        .robot_yaw (robot_yaw),
        .dn_valid  (cc_valid[0]),
        .dn_ready  (cc_ready[0]),
        .dn_item   (cc_item[0])
    );

    // bearing rotation and integer root advance side by side, one step a cell
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cord
        wsc_cord_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (5'(i)),
            .up_valid (cc_valid[i]),
            .up_ready (cc_ready[i]),
            .up_item  (cc_item[i]),
            .dn_valid (cc_valid[i+1]),
            .dn_ready (cc_ready[i+1]),
            .dn_item  (cc_item[i+1])
        );
    end

    // bearing, heading error, wheel angle, ratio operands
    wsc_mid u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (cc_valid[NCELL]),
        .up_ready (cc_ready[NCELL]),
        .up_item  (cc_item[NCELL]),
        .dn_valid (dv_valid[0]),
        .dn_ready (dv_ready[0]),
        .dn_item  (dv_item[0])
    );

    // turn speed ratio, one quotient bit a cell
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        wsc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv_valid[j]),
            .up_ready (dv_ready[j]),
            .up_item  (dv_item[j]),
            .dn_valid (dv_valid[j+1]),
            .dn_ready (dv_ready[j+1]),
            .dn_item  (dv_item[j+1])
        );
    end

    // select the command and hold it for the receiver
    wsc_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (dv_valid[DIV_STEPS]),
        .up_ready    (dv_ready[DIV_STEPS]),
        .up_item     (dv_item[DIV_STEPS]),
        .dn_valid    (out_valid),
        .dn_ready    (out_ready),
        .drive_mode  (drive_mode),
        .speed       (speed),
        .wheel_angle (wheel_angle)
    );

    `ASSERT_IMPLY(a_arrived_still, clk, rst_n,
        out_valid && drive_mode == MODE_ARRIVED, speed == 16'd0 && wheel_angle == 15'sd0)
    `ASSERT_IMPLY(a_forward_straight, clk, rst_n,
        out_valid && drive_mode == MODE_FORWARD, wheel_angle == 15'sd0)
    `ASSERT_IMPLY(a_stall_from_output, clk, rst_n,
        !in_ready, out_valid && !out_ready)
    `ASSERT_NEXT(a_reset_empty, clk, rst_n,
        !out_valid && !cc_valid[NCELL] && !dv_valid[DIV_STEPS] && !dv_valid[0], !out_valid)

endmodule
`default_nettype wire

// ===== dv/wsc_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module wsc_checker
    import wsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] robot_x,
    input  wire logic signed [15:0] robot_y,
    input  wire logic [15:0]        robot_yaw,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         drive_mode,
    input  wire logic [15:0]        speed,
    input  wire logic signed [14:0] wheel_angle,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] spd;
        logic [14:0] wheel;
    } command_t;

    command_t cmd_q[$];

    logic signed [15:0] wp_x, wp_y;
    logic [15:0] arr_tol, turn_max, move_max, full_dist;
    logic [14:0] yaw_tol;
    logic [13:0] wheel_max;

    localparam longint ARC[16] = '{4608000, 2720261, 1437311, 729602, 366217, 183287,
        91666, 45836, 22918, 11459, 5730, 2865, 1432, 716, 358, 179};

    // bearing in 0.01 deg, CORDIC vectoring with floor shifts
    function automatic longint bearing(longint dx, longint dy);
        longint x, y, z, xs, ys, t;
        x = dx * 16384;
        y = dy * 16384;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(FULL_TURN / 2) * 1024;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ARC[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ARC[i];
            end
        end
        if (z < 0)
            z += longint'(FULL_TURN) * 1024;
        t = (z + 512) / 1024;
        if (t >= FULL_TURN)
            t -= FULL_TURN;
        return t;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (longint b = 1 << 20; b > 0; b >>= 1)
            if ((r + b) * (r + b) <= v)
                r += b;
        return r;
    endfunction

    function automatic command_t steer(logic signed [15:0] rx, logic signed [15:0] ry,
                                       logic [15:0] ryaw);
        command_t c;
        longint dx, dy, d2, yaw, t, diff, err, yt, ang, lo, hi, span, off;
        bit seam, hold, neg;
        dx = longint'(wp_x) - longint'(rx);
        dy = longint'(wp_y) - longint'(ry);
        d2 = dx * dx + dy * dy;
        yaw = ryaw;
        yt = yaw_tol;
        if (yaw >= FULL_TURN)
            yaw -= FULL_TURN;
        c = '0;
        if (d2 <= longint'(arr_tol) * arr_tol)
        begin
            c.mode = MODE_ARRIVED;
            return c;
        end
        t = bearing(dx, dy);
        diff = t > yaw ? t - yaw : yaw - t;
        seam = (t > FULL_TURN - SEAM_TOLERANCE && yaw < SEAM_TOLERANCE) ||
               (yaw > FULL_TURN - SEAM_TOLERANCE && t < SEAM_TOLERANCE);
        err = seam ? FULL_TURN - diff : diff;
        hold = (t > FULL_TURN - yt && yaw < yt) || (yaw > FULL_TURN - yt && t < yt);
        if (!hold && err > yt)
        begin
            c.mode = MODE_TURN;
            ang = err;
            if (ang > wheel_max)
                ang = wheel_max;
            else if (ang < MIN_WHEEL_ANGLE)
                ang = MIN_WHEEL_ANGLE;
            if (yaw > t)
                neg = (FULL_TURN - yaw + t < yaw - t);
            else
                neg = !(FULL_TURN - t + yaw < t - yaw);
            c.wheel = 15'(neg ? -ang : ang);
            lo = err < t ? err : t;
            hi = err < t ? t : err;
            span = longint'(turn_max) - TURN_SPEED_FLOOR;
            off = 0;
            if (hi != 0)
                off = span >= 0 ? (span * lo) / hi : -(((-span) * lo) / hi);
            off += TURN_SPEED_FLOOR;
            if (off < 0)
                off = 0;
            if (off > 65535)
                off = 65535;
            c.spd = 16'(off);
        end
        else if (d2 > longint'(full_dist) * full_dist)
            c.spd = move_max;
        else
            c.spd = 16'(root_floor(d2) / FORWARD_DIVISOR);
        return c;
    endfunction

    assign pending = cmd_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        command_t e;
        if (!rst_n)
        begin
            wp_x <= 0; wp_y <= 0; arr_tol <= 10; yaw_tol <= 500;
            wheel_max <= 4500; turn_max <= 500; move_max <= 1000; full_dist <= 100;
            fail_count <= 0;
            cmd_q.delete();
        end
        else
        begin
            if (cfg_we)
                case (reg_idx_t'(cfg_index))
                    REG_WAYPOINT_X: wp_x <= cfg_data;
                    REG_WAYPOINT_Y: wp_y <= cfg_data;
                    REG_ARRIVE_TOL: arr_tol <= cfg_data;
                    REG_YAW_TOL:    yaw_tol <= cfg_data[14:0];
                    REG_MAX_WHEEL:  wheel_max <= cfg_data[13:0];
                    REG_MAX_TURN:   turn_max <= cfg_data;
                    REG_MAX_MOVE:   move_max <= cfg_data;
                    REG_FULL_DIST:  full_dist <= cfg_data;
                    default: ;
                endcase
            if (in_valid && in_ready)
                cmd_q.push_back(steer(robot_x, robot_y, robot_yaw));
            if (out_valid && out_ready)
            begin
                if (cmd_q.size() == 0)
                begin
                    $error("drive word with no pose outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (drive_mode !== e.mode || speed !== e.spd || wheel_angle !== e.wheel)
                    begin
                        fail_count <= fail_count + 1;
                        if (drive_mode !== e.mode)
                            $error("drive_mode expected %0d got %0d", e.mode, drive_mode);
                        if (speed !== e.spd)
                            $error("speed expected %0d got %0d", e.spd, speed);
                        if (wheel_angle !== e.wheel)
                            $error("wheel_angle expected %0d got %0d",
                                   $signed(e.wheel), wheel_angle);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== dv/waypoint_steering_controller_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module waypoint_steering_controller_unit_test;
    import wsc_pkg::*;

    logic clk, rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] robot_x, robot_y;
    logic [15:0] robot_yaw;
    logic [1:0] drive_mode;
    logic [15:0] speed;
    logic signed [14:0] wheel_angle;
    int fail_count, pending;
    longint cycle;
    int stall_mode;

    // latency of the pipe, and a hard ceiling on the whole run
    localparam int PIPE_DEPTH = 40;
    localparam longint CYCLE_LIMIT = 400000;

    waypoint_steering_controller_unit u_top (.*);

    wsc_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Count cycles; abandon the run if it hangs.
    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > CYCLE_LIMIT)
            begin
                $display("FAIL waypoint_steering_controller_unit");
                $finish;
            end
        end
    end

    // Receiver: stall pattern switches between always-ready, heavy stalls and light ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Write one register at a clock edge while the pipe is empty, then lower cfg_we.
    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one pose word and hold it until taken; pause_sender leaves the gap.
    task automatic send_pose(logic [15:0] x, logic [15:0] y, logic [15:0] yaw);
        in_valid <= 1'b1;
        robot_x <= x;
        robot_y <= y;
        robot_yaw <= yaw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Drain: wait until every drive word has come back, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    // Random pose: mostly near the waypoint so all three modes appear.
    task automatic random_pose(logic signed [15:0] wx, logic signed [15:0] wy);
        logic [15:0] x, y, yaw;
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            x = wx + $signed(16'($urandom_range(0, 60))) - 16'sd30;
            y = wy + $signed(16'($urandom_range(0, 60))) - 16'sd30;
        end
        else if (r < 7)
        begin
            x = wx + $signed(16'($urandom_range(0, 800))) - 16'sd400;
            y = wy + $signed(16'($urandom_range(0, 800))) - 16'sd400;
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        r = $urandom_range(0, 9);
        if (r < 2)
            yaw = 16'($urandom_range(0, 1500));
        else if (r < 4)
            yaw = 16'($urandom_range(34500, 35999));
        else if (r == 4)
            yaw = 16'($urandom_range(36000, 65535));
        else
            yaw = 16'($urandom_range(0, 35999));
        send_pose(x, y, yaw);
    endtask

    initial
    begin
        logic signed [15:0] wx, wy;
        int burst;
        stall_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WAYPOINT_X;
        cfg_data = '0;
        in_valid = 1'b0;
        robot_x = '0;
        robot_y = '0;
        robot_yaw = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings; on the waypoint, each quadrant, seam, big yaw.
        send_pose(0, 0, 0);
        send_pose(16'sh7FFF, 16'sh7FFF, 35999);
        send_pose(16'sh8000, 16'sh8000, 0);
        send_pose(16'sh8000, 16'sh7FFF, 65535);
        send_pose(-100, 0, 0);
        send_pose(-100, 5, 35900);
        send_pose(-100, -5, 100);
        send_pose(100, 0, 9000);
        send_pose(0, 100, 0);
        send_pose(0, -100, 18000);
        send_pose(7, 7, 1234);
        send_pose(-40, 0, 27000);
        send_pose(-40, 0, 36000);
        send_pose(-20, 300, 4000);
        drain();

        // Extremes of every register.
        write_reg(REG_WAYPOINT_X, 16'h7FFF);
        write_reg(REG_WAYPOINT_Y, 16'h8000);
        write_reg(REG_ARRIVE_TOL, 0);
        write_reg(REG_YAW_TOL, 0);
        write_reg(REG_MAX_WHEEL, 9000);
        write_reg(REG_MAX_TURN, 16'hFFFF);
        write_reg(REG_MAX_MOVE, 16'hFFFF);
        write_reg(REG_FULL_DIST, 16'hFFFF);
        send_pose(16'h7FFF, 16'h8000, 0);
        send_pose(16'h8000, 16'h7FFF, 18000);
        send_pose(16'h7FFF, 16'h7FFF, 35999);
        send_pose(0, 0, 27000);
        drain();
        write_reg(REG_ARRIVE_TOL, 16'hFFFF);
        write_reg(REG_YAW_TOL, 18000);
        write_reg(REG_MAX_WHEEL, 0);
        write_reg(REG_MAX_TURN, 0);
        write_reg(REG_MAX_MOVE, 0);
        write_reg(REG_FULL_DIST, 0);
        send_pose(0, 0, 100);
        send_pose(16'h8000, 16'h7FFF, 9000);
        drain();

        // Random phases, each with a fresh configuration.
        for (int phase = 0; phase < 9; phase++)
        begin
            wx = 16'($urandom);
            wy = 16'($urandom);
            if (phase % 3 == 0)
            begin
                wx = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
                wy = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
            end
            write_reg(REG_WAYPOINT_X, wx);
            write_reg(REG_WAYPOINT_Y, wy);
            write_reg(REG_ARRIVE_TOL, phase == 4 ? 16'($urandom) : 16'($urandom_range(0, 40)));
            write_reg(REG_YAW_TOL, phase == 5 ? 16'd18000 : 16'($urandom_range(0, 3000)));
            write_reg(REG_MAX_WHEEL, 16'($urandom_range(0, 9000)));
            write_reg(REG_MAX_TURN, phase == 2 ? 16'd50 : 16'($urandom));
            write_reg(REG_MAX_MOVE, 16'($urandom));
            write_reg(REG_FULL_DIST, 16'($urandom_range(0, 600)));
            for (int n = 0; n < 100; )
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 100; b++, n++)
                    random_pose(wx, wy);
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS waypoint_steering_controller_unit");
        else
            $display("FAIL waypoint_steering_controller_unit");
        $finish;
    end

endmodule
`default_nettype wire
